// ----- sv/pid_antiwindup_controller_assert.svh -----
// Assertion helpers for the PID controller checker.
`ifndef PID_ANTIWINDUP_CONTROLLER_ASSERT_SVH
`define PID_ANTIWINDUP_CONTROLLER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define PIDAW_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pid_antiwindup_controller assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define PIDAW_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pid_antiwindup_controller assertion failed");

`endif

// ----- sv/pidaw_pkg.sv -----
`default_nettype none

package pidaw_pkg;

   localparam int FRAC_BITS = 16;

   localparam logic signed [31:0] SETPOINT_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] SETPOINT_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] FX_ONE = 32'(64'sd1 <<< FRAC_BITS);
   localparam logic signed [31:0] FX_TWO = 32'(64'sd2 <<< FRAC_BITS);

   localparam logic [1:0] METHOD_FWD  = 2'd0;
   localparam logic [1:0] METHOD_BWD  = 2'd1;
   localparam logic [1:0] METHOD_TRAP = 2'd2;

   localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
   localparam logic [2:0] REG_INTEG_GAIN    = 3'd1;
   localparam logic [2:0] REG_DERIV_GAIN    = 3'd2;
   localparam logic [2:0] REG_FILTER_COEF   = 3'd3;
   localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd4;
   localparam logic [2:0] REG_METHOD_SEL    = 3'd5;
   localparam logic [2:0] REG_OUT_MIN       = 3'd6;
   localparam logic [2:0] REG_OUT_MAX       = 3'd7;

   localparam logic [4:0] SRC_ZERO = 5'd0;
   localparam logic [4:0] SRC_SP   = 5'd1;
   localparam logic [4:0] SRC_FB   = 5'd2;
   localparam logic [4:0] SRC_E1   = 5'd3;
   localparam logic [4:0] SRC_E2   = 5'd4;
   localparam logic [4:0] SRC_C1   = 5'd5;
   localparam logic [4:0] SRC_C2   = 5'd6;
   localparam logic [4:0] SRC_KP   = 5'd7;
   localparam logic [4:0] SRC_KI   = 5'd8;
   localparam logic [4:0] SRC_KD   = 5'd9;
   localparam logic [4:0] SRC_N    = 5'd10;
   localparam logic [4:0] SRC_DT   = 5'd11;
   localparam logic [4:0] SRC_ONE  = 5'd12;
   localparam logic [4:0] SRC_TWO  = 5'd13;
   localparam logic [4:0] SRC_E0   = 5'd14;
   localparam logic [4:0] SRC_C    = 5'd15;
   localparam logic [4:0] TMP0     = 5'd16;
   localparam logic [4:0] TMP1     = 5'd17;
   localparam logic [4:0] TMP2     = 5'd18;
   localparam logic [4:0] TMP3     = 5'd19;
   localparam logic [4:0] TMP4     = 5'd20;
   localparam logic [4:0] TMP5     = 5'd21;
   localparam logic [4:0] TMP6     = 5'd22;
   localparam logic [4:0] TMP7     = 5'd23;
   localparam logic [4:0] TMP8     = 5'd24;
   localparam logic [4:0] TMP9     = 5'd25;
   localparam logic [4:0] TMP10    = 5'd26;
   localparam logic [4:0] TMP11    = 5'd27;
   localparam logic [4:0] TMP12    = 5'd28;

   localparam logic [6:0] M0_BASE = 7'd13;
   localparam logic [6:0] M1_BASE = 7'd36;
   localparam logic [6:0] M2_BASE = 7'd59;
   localparam logic [6:0] M3_BASE = 7'd91;

   typedef enum logic [3:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_SQRT,
      OP_ABS,
      OP_SELNZ,
      OP_SATERR,
      OP_CLAMPSP
   } alu_op_type;

   typedef enum logic [1:0] {
      FL_NONE,
      FL_BRANCH,
      FL_LAST
   } flow_type;

   typedef struct packed {
      alu_op_type op;
      logic [4:0] dst;
      logic [4:0] a;
      logic [4:0] b;
      flow_type   flow;
   } instr_type;

   typedef struct packed {
      logic signed [31:0] target;
      logic signed [31:0] measured;
   } req_type;

   typedef struct packed {
      logic signed [31:0] drive;
      logic signed [31:0] error_now;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] target;
      logic signed [31:0] measured;
      logic signed [31:0] e1;
      logic signed [31:0] e2;
      logic signed [31:0] c1;
      logic signed [31:0] c2;
      logic signed [31:0] kp;
      logic signed [31:0] ki;
      logic signed [31:0] kd;
      logic [30:0]        n;
      logic [30:0]        dt;
      logic [1:0]         method;
      logic signed [31:0] out_min;
      logic signed [31:0] out_max;
   } ctx_type;

   typedef struct packed {
      logic               start;
      alu_op_type         op;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] lo;
      logic signed [31:0] hi;
   } alu_req_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] result;
   } alu_rsp_type;

   typedef struct packed {
      logic               idle;
      logic               done;
      logic signed [31:0] e0;
      logic signed [31:0] c;
   } seq_stat_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7fff_ffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic instr_type mk(input alu_op_type op, input logic [4:0] dst,
                                    input logic [4:0] a, input logic [4:0] b,
                                    input flow_type flow);
      instr_type r;
      r.op = op;
      r.dst = dst;
      r.a = a;
      r.b = b;
      r.flow = flow;
      return r;
   endfunction

   function automatic instr_type prog(input logic [6:0] pc);
      instr_type r;
      case (pc)
         // shared prologue: kt, error, nt, derivative term
         7'd0:  r = mk(OP_ABS,     TMP0,   SRC_KI,  SRC_ZERO, FL_NONE);
         7'd1:  r = mk(OP_SELNZ,   TMP1,   SRC_KD,  SRC_KP,   FL_NONE);
         7'd2:  r = mk(OP_ABS,     TMP1,   TMP1,    SRC_ZERO, FL_NONE);
         7'd3:  r = mk(OP_DIV,     TMP0,   TMP0,    TMP1,     FL_NONE);
         7'd4:  r = mk(OP_SQRT,    TMP2,   TMP0,    SRC_ZERO, FL_NONE);
         7'd5:  r = mk(OP_CLAMPSP, TMP3,   SRC_SP,  SRC_ZERO, FL_NONE);
         7'd6:  r = mk(OP_SUB,     SRC_E0, TMP3,    SRC_FB,   FL_NONE);
         7'd7:  r = mk(OP_MUL,     TMP3,   SRC_N,   SRC_DT,   FL_NONE);
         7'd8:  r = mk(OP_MUL,     TMP4,   SRC_KD,  SRC_N,    FL_NONE);
         7'd9:  r = mk(OP_ADD,     TMP5,   SRC_E1,  SRC_E1,   FL_NONE);
         7'd10: r = mk(OP_SUB,     TMP5,   SRC_E0,  TMP5,     FL_NONE);
         7'd11: r = mk(OP_ADD,     TMP5,   TMP5,    SRC_E2,   FL_NONE);
         7'd12: r = mk(OP_MUL,     TMP4,   TMP4,    TMP5,     FL_BRANCH);
         // forward Euler
         7'd13: r = mk(OP_SUB,     TMP5,   TMP3,    SRC_ONE,  FL_NONE);
         7'd14: r = mk(OP_SUB,     TMP6,   TMP3,    SRC_TWO,  FL_NONE);
         7'd15: r = mk(OP_MUL,     TMP7,   TMP6,    SRC_E1,   FL_NONE);
         7'd16: r = mk(OP_ADD,     TMP7,   SRC_E0,  TMP7,     FL_NONE);
         7'd17: r = mk(OP_MUL,     TMP8,   TMP5,    SRC_E2,   FL_NONE);
         7'd18: r = mk(OP_SUB,     TMP7,   TMP7,    TMP8,     FL_NONE);
         7'd19: r = mk(OP_MUL,     TMP7,   SRC_KP,  TMP7,     FL_NONE);
         7'd20: r = mk(OP_MUL,     TMP9,   SRC_KI,  SRC_DT,   FL_NONE);
         7'd21: r = mk(OP_SUB,     TMP10,  SRC_E1,  TMP8,     FL_NONE);
         7'd22: r = mk(OP_MUL,     TMP9,   TMP9,    TMP10,    FL_NONE);
         7'd23: r = mk(OP_MUL,     TMP10,  TMP2,    SRC_DT,   FL_NONE);
         7'd24: r = mk(OP_SATERR,  TMP11,  SRC_C1,  SRC_ZERO, FL_NONE);
         7'd25: r = mk(OP_SATERR,  TMP12,  SRC_C2,  SRC_ZERO, FL_NONE);
         7'd26: r = mk(OP_MUL,     TMP12,  TMP5,    TMP12,    FL_NONE);
         7'd27: r = mk(OP_SUB,     TMP11,  TMP11,   TMP12,    FL_NONE);
         7'd28: r = mk(OP_MUL,     TMP10,  TMP10,   TMP11,    FL_NONE);
         7'd29: r = mk(OP_ADD,     TMP0,   TMP7,    TMP9,     FL_NONE);
         7'd30: r = mk(OP_ADD,     TMP0,   TMP0,    TMP10,    FL_NONE);
         7'd31: r = mk(OP_ADD,     TMP0,   TMP0,    TMP4,     FL_NONE);
         7'd32: r = mk(OP_MUL,     TMP1,   TMP5,    SRC_C2,   FL_NONE);
         7'd33: r = mk(OP_ADD,     TMP0,   TMP0,    TMP1,     FL_NONE);
         7'd34: r = mk(OP_MUL,     TMP1,   TMP6,    SRC_C1,   FL_NONE);
         7'd35: r = mk(OP_SUB,     SRC_C,  TMP0,    TMP1,     FL_LAST);
         // backward Euler
         7'd36: r = mk(OP_ADD,     TMP5,   TMP3,    SRC_ONE,  FL_NONE);
         7'd37: r = mk(OP_ADD,     TMP6,   TMP3,    SRC_TWO,  FL_NONE);
         7'd38: r = mk(OP_MUL,     TMP7,   TMP5,    SRC_E0,   FL_NONE);
         7'd39: r = mk(OP_ADD,     TMP7,   TMP7,    SRC_E2,   FL_NONE);
         7'd40: r = mk(OP_MUL,     TMP8,   TMP6,    SRC_E1,   FL_NONE);
         7'd41: r = mk(OP_SUB,     TMP7,   TMP7,    TMP8,     FL_NONE);
         7'd42: r = mk(OP_MUL,     TMP7,   SRC_KP,  TMP7,     FL_NONE);
         7'd43: r = mk(OP_MUL,     TMP9,   SRC_KI,  SRC_DT,   FL_NONE);
         7'd44: r = mk(OP_MUL,     TMP8,   TMP5,    SRC_E0,   FL_NONE);
         7'd45: r = mk(OP_ADD,     TMP8,   TMP8,    SRC_E1,   FL_NONE);
         7'd46: r = mk(OP_MUL,     TMP9,   TMP9,    TMP8,     FL_NONE);
         7'd47: r = mk(OP_MUL,     TMP10,  TMP2,    SRC_DT,   FL_NONE);
         7'd48: r = mk(OP_SATERR,  TMP11,  SRC_C1,  SRC_ZERO, FL_NONE);
         7'd49: r = mk(OP_MUL,     TMP12,  TMP5,    TMP11,    FL_NONE);
         7'd50: r = mk(OP_ADD,     TMP11,  TMP12,   TMP11,    FL_NONE);
         7'd51: r = mk(OP_MUL,     TMP10,  TMP10,   TMP11,    FL_NONE);
         7'd52: r = mk(OP_ADD,     TMP0,   TMP7,    TMP9,     FL_NONE);
         7'd53: r = mk(OP_ADD,     TMP0,   TMP0,    TMP10,    FL_NONE);
         7'd54: r = mk(OP_ADD,     TMP0,   TMP0,    TMP4,     FL_NONE);
         7'd55: r = mk(OP_MUL,     TMP1,   TMP6,    SRC_C1,   FL_NONE);
         7'd56: r = mk(OP_ADD,     TMP0,   TMP0,    TMP1,     FL_NONE);
         7'd57: r = mk(OP_SUB,     TMP0,   TMP0,    SRC_C2,   FL_NONE);
         7'd58: r = mk(OP_DIV,     SRC_C,  TMP0,    TMP5,     FL_LAST);
         // trapezoidal
         7'd59: r = mk(OP_SUB,     TMP0,   TMP3,    SRC_TWO,  FL_NONE);
         7'd60: r = mk(OP_DIV,     TMP5,   TMP0,    SRC_TWO,  FL_NONE);
         7'd61: r = mk(OP_ADD,     TMP0,   TMP3,    SRC_TWO,  FL_NONE);
         7'd62: r = mk(OP_DIV,     TMP6,   TMP0,    SRC_TWO,  FL_NONE);
         7'd63: r = mk(OP_MUL,     TMP7,   TMP6,    SRC_E0,   FL_NONE);
         7'd64: r = mk(OP_ADD,     TMP8,   SRC_E1,  SRC_E1,   FL_NONE);
         7'd65: r = mk(OP_ADD,     TMP7,   TMP7,    TMP8,     FL_NONE);
         7'd66: r = mk(OP_MUL,     TMP8,   TMP5,    SRC_E2,   FL_NONE);
         7'd67: r = mk(OP_SUB,     TMP7,   TMP7,    TMP8,     FL_NONE);
         7'd68: r = mk(OP_MUL,     TMP7,   TMP7,    SRC_KP,   FL_NONE);
         7'd69: r = mk(OP_MUL,     TMP9,   TMP6,    SRC_E0,   FL_NONE);
         7'd70: r = mk(OP_MUL,     TMP8,   TMP3,    SRC_E1,   FL_NONE);
         7'd71: r = mk(OP_ADD,     TMP9,   TMP9,    TMP8,     FL_NONE);
         7'd72: r = mk(OP_MUL,     TMP8,   TMP5,    SRC_E2,   FL_NONE);
         7'd73: r = mk(OP_ADD,     TMP9,   TMP9,    TMP8,     FL_NONE);
         7'd74: r = mk(OP_MUL,     TMP9,   TMP9,    SRC_KI,   FL_NONE);
         7'd75: r = mk(OP_MUL,     TMP9,   TMP9,    SRC_DT,   FL_NONE);
         7'd76: r = mk(OP_DIV,     TMP9,   TMP9,    SRC_TWO,  FL_NONE);
         7'd77: r = mk(OP_SATERR,  TMP11,  SRC_C1,  SRC_ZERO, FL_NONE);
         7'd78: r = mk(OP_MUL,     TMP10,  TMP6,    TMP11,    FL_NONE);
         7'd79: r = mk(OP_MUL,     TMP12,  TMP3,    TMP11,    FL_NONE);
         7'd80: r = mk(OP_ADD,     TMP10,  TMP10,   TMP12,    FL_NONE);
         7'd81: r = mk(OP_SATERR,  TMP12,  SRC_C2,  SRC_ZERO, FL_NONE);
         7'd82: r = mk(OP_MUL,     TMP12,  TMP5,    TMP12,    FL_NONE);
         7'd83: r = mk(OP_ADD,     TMP10,  TMP10,   TMP12,    FL_NONE);
         7'd84: r = mk(OP_MUL,     TMP10,  TMP10,   TMP2,     FL_NONE);
         7'd85: r = mk(OP_MUL,     TMP10,  TMP10,   SRC_DT,   FL_NONE);
         7'd86: r = mk(OP_DIV,     TMP10,  TMP10,   SRC_TWO,  FL_NONE);
         7'd87: r = mk(OP_ADD,     TMP0,   TMP7,    TMP9,     FL_NONE);
         7'd88: r = mk(OP_ADD,     TMP0,   TMP0,    TMP10,    FL_NONE);
         7'd89: r = mk(OP_ADD,     TMP0,   TMP0,    TMP4,     FL_NONE);
         7'd90: r = mk(OP_DIV,     SRC_C,  TMP0,    TMP6,     FL_LAST);
         // unused method: hold the output
         7'd91: r = mk(OP_ADD,     SRC_C,  SRC_C1,  SRC_ZERO, FL_LAST);
         default: r = mk(OP_ADD,   SRC_C,  SRC_C1,  SRC_ZERO, FL_LAST);
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- sv/pidaw_alu.sv -----
`default_nettype none

module pidaw_alu (
   input  logic                  clock,
   input  logic                  reset,
   input  pidaw_pkg::alu_req_type req,
   output pidaw_pkg::alu_rsp_type rsp
);
   import pidaw_pkg::*;

   localparam int DW = 32 + FRAC_BITS;
   localparam int SQ = (32 + FRAC_BITS) / 2;
   localparam int XW = 2 * SQ;
   localparam int CW = $clog2(DW + 1);

   typedef enum logic [3:0] {
      A_IDLE = 4'b0001,
      A_DIV  = 4'b0010,
      A_SQRT = 4'b0100,
      A_FIN  = 4'b1000
   } alu_state_type;

   alu_state_type      state_ff, state_in;
   logic [DW-1:0]      dvd_ff, dvd_in;
   logic [31:0]        rem_ff, rem_in;
   logic [31:0]        dvs_ff, dvs_in;
   logic               neg_ff, neg_in;
   logic [XW-1:0]      x_ff, x_in;
   logic [SQ+1:0]      srem_ff, srem_in;
   logic [SQ-1:0]      root_ff, root_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               is_div_ff, is_div_in;
   logic signed [31:0] res_ff, res_in;
   logic               done_ff, done_in;

   logic signed [63:0] a64, b64, lo64, hi64, prod, qs;
   logic signed [31:0] simple;
   logic [31:0]        abs_a, abs_b;
   logic [32:0]        rem_sh;
   logic               div_ge, sq_ge;
   logic [SQ+1:0]      sr_sh, trial;

   always_comb begin
      a64 = req.a;
      b64 = req.b;
      lo64 = req.lo;
      hi64 = req.hi;
      prod = ((a64 * b64) + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      abs_a = req.a[31] ? (~req.a + 32'd1) : req.a;
      abs_b = req.b[31] ? (~req.b + 32'd1) : req.b;
      case (req.op)
         OP_ADD:     simple = sat32(a64 + b64);
         OP_SUB:     simple = sat32(a64 - b64);
         OP_MUL:     simple = sat32(prod);
         OP_ABS:     simple = req.a[31] ? sat32(-a64) : req.a;
         OP_SELNZ:   simple = (req.a != 32'sd0) ? req.a : req.b;
         OP_SATERR: begin
            if (req.a > req.hi) begin
               simple = sat32(hi64 - a64);
            end else if (req.a < req.lo) begin
               simple = sat32(lo64 - a64);
            end else begin
               simple = 32'sd0;
            end
         end
         OP_CLAMPSP: begin
            if (req.a > SETPOINT_MAX) begin
               simple = SETPOINT_MAX;
            end else if (req.a < SETPOINT_MIN) begin
               simple = SETPOINT_MIN;
            end else begin
               simple = req.a;
            end
         end
         default:    simple = 32'sd0;
      endcase

      rem_sh = {rem_ff, dvd_ff[DW-1]};
      div_ge = rem_sh >= {1'b0, dvs_ff};
      sr_sh = {srem_ff[SQ-1:0], x_ff[XW-1:XW-2]};
      trial = {root_ff, 2'b01};
      sq_ge = sr_sh >= trial;
      qs = signed'(64'(dvd_ff));
   end

   always_comb begin
      state_in = state_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      neg_in = neg_ff;
      x_in = x_ff;
      srem_in = srem_ff;
      root_in = root_ff;
      cnt_in = cnt_ff;
      is_div_in = is_div_ff;
      res_in = res_ff;
      done_in = 1'b0;
      case (state_ff)
         A_IDLE: begin
            if (req.start) begin
               cnt_in = '0;
               if (req.op == OP_DIV) begin
                  if (req.b == 32'sd0) begin
                     res_in = (req.a == 32'sd0) ? 32'sd0 :
                              (req.a[31] ? 32'sh8000_0000 : 32'sh7fff_ffff);
                     done_in = 1'b1;
                  end else begin
                     dvd_in = DW'(abs_a) << FRAC_BITS;
                     dvs_in = abs_b;
                     rem_in = '0;
                     neg_in = req.a[31] ^ req.b[31];
                     is_div_in = 1'b1;
                     state_in = A_DIV;
                  end
               end else if (req.op == OP_SQRT) begin
                  if (req.a <= 32'sd0) begin
                     res_in = 32'sd0;
                     done_in = 1'b1;
                  end else begin
                     x_in = XW'(req.a[30:0]) << FRAC_BITS;
                     srem_in = '0;
                     root_in = '0;
                     is_div_in = 1'b0;
                     state_in = A_SQRT;
                  end
               end else begin
                  res_in = simple;
                  done_in = 1'b1;
               end
            end
         end
         A_DIV: begin
            rem_in = div_ge ? 32'(rem_sh - {1'b0, dvs_ff}) : rem_sh[31:0];
            dvd_in = {dvd_ff[DW-2:0], div_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(DW - 1)) begin
               state_in = A_FIN;
            end
         end
         A_SQRT: begin
            srem_in = sq_ge ? (sr_sh - trial) : sr_sh;
            root_in = {root_ff[SQ-2:0], sq_ge};
            x_in = x_ff << 2;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(SQ - 1)) begin
               state_in = A_FIN;
            end
         end
         A_FIN: begin
            if (is_div_ff) begin
               res_in = sat32(neg_ff ? -qs : qs);
            end else begin
               res_in = 32'(root_ff);
            end
            done_in = 1'b1;
            state_in = A_IDLE;
         end
         default: state_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      x_ff <= x_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      cnt_ff <= cnt_in;
      is_div_ff <= is_div_in;
      res_ff <= res_in;
   end

   assign rsp.done = done_ff;
   assign rsp.result = res_ff;

endmodule

`default_nettype wire

// ----- sv/pidaw_seq.sv -----
`default_nettype none

module pidaw_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   commit_ok,
   input  pidaw_pkg::ctx_type      ctx,
   input  pidaw_pkg::alu_rsp_type  alu_rsp,
   output pidaw_pkg::alu_req_type  alu_req,
   output pidaw_pkg::seq_stat_type stat
);
   import pidaw_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_FETCH = 5'b00010,
      S_ISSUE = 5'b00100,
      S_WAIT  = 5'b01000,
      S_DONE  = 5'b10000
   } seq_state_type;

   seq_state_type      state_ff, state_in;
   logic [6:0]         pc_ff, pc_in;
   logic signed [31:0] e0_ff, e0_in;
   logic signed [31:0] c_ff, c_in;
   logic signed [31:0] nam_a_ff, nam_b_ff;
   logic               tmp_a_ff, tmp_b_ff;
   logic [31:0]        rd_a_ff, rd_b_ff;
   logic [31:0]        tmp_mem [16];
   logic               wr_en;
   instr_type          instr;
   logic [6:0]         branch_pc;

   function automatic logic signed [31:0] named(input logic [4:0] src, input ctx_type x,
                                                input logic signed [31:0] e0);
      logic signed [31:0] r;
      case (src)
         SRC_SP:  r = x.target;
         SRC_FB:  r = x.measured;
         SRC_E1:  r = x.e1;
         SRC_E2:  r = x.e2;
         SRC_C1:  r = x.c1;
         SRC_C2:  r = x.c2;
         SRC_KP:  r = x.kp;
         SRC_KI:  r = x.ki;
         SRC_KD:  r = x.kd;
         SRC_N:   r = {1'b0, x.n};
         SRC_DT:  r = {1'b0, x.dt};
         SRC_ONE: r = FX_ONE;
         SRC_TWO: r = FX_TWO;
         SRC_E0:  r = e0;
         default: r = 32'sd0;
      endcase
      return r;
   endfunction

   always_comb begin
      instr = prog(pc_ff);
      case (ctx.method)
         METHOD_FWD:  branch_pc = M0_BASE;
         METHOD_BWD:  branch_pc = M1_BASE;
         METHOD_TRAP: branch_pc = M2_BASE;
         default:     branch_pc = M3_BASE;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      pc_in = pc_ff;
      e0_in = e0_ff;
      c_in = c_ff;
      wr_en = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               pc_in = '0;
               state_in = S_FETCH;
            end
         end
         S_FETCH: state_in = S_ISSUE;
         S_ISSUE: state_in = S_WAIT;
         S_WAIT: begin
            if (alu_rsp.done) begin
               if (instr.dst == SRC_E0) begin
                  e0_in = alu_rsp.result;
               end else if (instr.dst == SRC_C) begin
                  c_in = alu_rsp.result;
               end else begin
                  wr_en = 1'b1;
               end
               if (instr.flow == FL_LAST) begin
                  state_in = S_DONE;
               end else begin
                  pc_in = (instr.flow == FL_BRANCH) ? branch_pc : pc_ff + 7'd1;
                  state_in = S_FETCH;
               end
            end
         end
         S_DONE: begin
            if (commit_ok) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      pc_ff <= pc_in;
      e0_ff <= e0_in;
      c_ff <= c_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tmp_mem[instr.dst[3:0]] <= alu_rsp.result;
      end
      rd_a_ff <= tmp_mem[instr.a[3:0]];
      rd_b_ff <= tmp_mem[instr.b[3:0]];
      nam_a_ff <= named(instr.a, ctx, e0_ff);
      nam_b_ff <= named(instr.b, ctx, e0_ff);
      tmp_a_ff <= instr.a[4];
      tmp_b_ff <= instr.b[4];
   end

   assign alu_req.start = (state_ff == S_ISSUE);
   assign alu_req.op = instr.op;
   assign alu_req.a = tmp_a_ff ? signed'(rd_a_ff) : nam_a_ff;
   assign alu_req.b = tmp_b_ff ? signed'(rd_b_ff) : nam_b_ff;
   assign alu_req.lo = ctx.out_min;
   assign alu_req.hi = ctx.out_max;

   assign stat.idle = (state_ff == S_IDLE);
   assign stat.done = (state_ff == S_DONE) && commit_ok;
   assign stat.e0 = e0_ff;
   assign stat.c = c_ff;

endmodule

`default_nettype wire

// ----- sv/pid_antiwindup_controller.sv -----
// PID controller with filtered derivative and back-calculation anti-windup.
// Request channel: req_valid/req_stall carry target and measured (Q16.16).
// A request is taken when req_valid is high and req_stall is low; the block
// raises req_stall from the cycle after acceptance until the result is
// committed to the response register.
// Response channel: rsp_valid/rsp_stall carry drive and error_now. A held
// response stays stable while rsp_stall is high; a new request may be
// accepted while it waits, and its result is committed once the slot frees.
// Configuration: csr_valid/csr_ready write csr_wdata to register csr_index;
// csr_ready is always high. Write only while the block is idle.
// Operation: each request runs a microprogram of 14 to 45 operations through
// one shared arithmetic unit, issued one at a time; divides and square roots
// run bit-serially, other operations are computed combinationally and
// registered. A new request is taken only after the previous result is committed.
// Reset clears the histories, restores register defaults and drops any
// pending response.
`default_nettype none

module pid_antiwindup_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pidaw_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output pidaw_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import pidaw_pkg::*;

   logic signed [31:0] kp_ff, ki_ff, kd_ff, out_min_ff, out_max_ff;
   logic [30:0]        n_ff, dt_ff;
   logic [1:0]         method_ff;
   logic signed [31:0] e1_ff, e2_ff, c1_ff, c2_ff;
   req_type            req_ff;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept, commit_ok;
   ctx_type            ctx;
   alu_req_type        alu_req;
   alu_rsp_type        alu_rsp;
   seq_stat_type       stat;

   assign accept = req_valid && !req_stall;
   assign commit_ok = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !stat.idle;
   assign csr_ready = 1'b1;

   always_comb begin
      ctx.target = req_ff.target;
      ctx.measured = req_ff.measured;
      ctx.e1 = e1_ff;
      ctx.e2 = e2_ff;
      ctx.c1 = c1_ff;
      ctx.c2 = c2_ff;
      ctx.kp = kp_ff;
      ctx.ki = ki_ff;
      ctx.kd = kd_ff;
      ctx.n = n_ff;
      ctx.dt = dt_ff;
      ctx.method = method_ff;
      ctx.out_min = out_min_ff;
      ctx.out_max = out_max_ff;
   end

   pidaw_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   pidaw_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .commit_ok (commit_ok),
      .ctx       (ctx),
      .alu_rsp   (alu_rsp),
      .alu_req   (alu_req),
      .stat      (stat)
   );

   always_comb begin
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (stat.done) begin
         if (stat.c > out_max_ff) begin
            rsp_in.drive = out_max_ff;
         end else if (stat.c < out_min_ff) begin
            rsp_in.drive = out_min_ff;
         end else begin
            rsp_in.drive = stat.c;
         end
         rsp_in.error_now = stat.e0;
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff <= 32'sd65536;
         ki_ff <= 32'sd0;
         kd_ff <= 32'sd0;
         n_ff <= 31'd65536;
         dt_ff <= 31'd65536;
         method_ff <= METHOD_FWD;
         out_min_ff <= 32'sh8000_0000;
         out_max_ff <= 32'sh7fff_ffff;
         e1_ff <= 32'sd0;
         e2_ff <= 32'sd0;
         c1_ff <= 32'sd0;
         c2_ff <= 32'sd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_PROP_GAIN:     kp_ff <= csr_wdata;
               REG_INTEG_GAIN:    ki_ff <= csr_wdata;
               REG_DERIV_GAIN:    kd_ff <= csr_wdata;
               REG_FILTER_COEF:   n_ff <= csr_wdata[30:0];
               REG_SAMPLE_PERIOD: dt_ff <= csr_wdata[30:0];
               REG_METHOD_SEL:    method_ff <= csr_wdata[1:0];
               REG_OUT_MIN:       out_min_ff <= csr_wdata;
               REG_OUT_MAX:       out_max_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (stat.done) begin
            e2_ff <= e1_ff;
            e1_ff <= stat.e0;
            c2_ff <= c1_ff;
            c1_ff <= stat.c;
         end
      end
      if (accept) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// ----- sv/pidaw_checker.sv -----
`default_nettype none

`include "pid_antiwindup_controller_assert.svh"

module pidaw_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input pidaw_pkg::rsp_type rsp_data
);

   `PIDAW_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)
   `PIDAW_ASSERT_NOW(a_rsp_from_busy, $rose(rsp_valid), $past(req_stall))
   `PIDAW_ASSERT_NEXT(a_rsp_hold_valid, rsp_valid && rsp_stall, rsp_valid)
   `PIDAW_ASSERT_NEXT(a_rsp_hold_data, rsp_valid && rsp_stall, $stable(rsp_data))

endmodule

bind pid_antiwindup_controller pidaw_checker u_pidaw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ----- sim/pid_antiwindup_controller_check.sv -----
`default_nettype none

module pid_antiwindup_controller_check
   import pidaw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   longint kp, ki, kd, filt_n, period, lim_lo, lim_hi;
   logic [1:0] method;
   longint c_hist1, c_hist2, e_hist1, e_hist2;
   rsp_type drive_q[$];

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint qadd(longint a, longint b);
      return clip32(a + b);
   endfunction

   function automatic longint qsub(longint a, longint b);
      return clip32(a - b);
   endfunction

   function automatic longint qmul(longint a, longint b);
      longint p;
      p = a * b + (64'sd1 <<< (FRAC_BITS - 1));
      return clip32(p >>> FRAC_BITS);
   endfunction

   function automatic longint qdiv(longint a, longint b);
      if (b == 0) begin
         if (a == 0) return 0;
         return (a > 0) ? 64'sd2147483647 : -64'sd2147483648;
      end
      return clip32((a <<< FRAC_BITS) / b);
   endfunction

   function automatic longint qabs(longint a);
      return clip32(a < 0 ? -a : a);
   endfunction

   function automatic longint qsqrt(longint v);
      longint unsigned x, r, bit_w;
      r = 0;
      bit_w = 64'd1 << 62;
      if (v <= 0) return 0;
      x = longint'(v) << FRAC_BITS;
      while (bit_w > x) bit_w >>= 2;
      while (bit_w != 0) begin
         if (x >= r + bit_w) begin
            x -= r + bit_w;
            r = (r >> 1) + bit_w;
         end else begin
            r >>= 1;
         end
         bit_w >>= 2;
      end
      return clip32(longint'(r));
   endfunction

   function automatic longint windup_err(longint c);
      if (c > lim_hi) return qsub(lim_hi, c);
      if (c < lim_lo) return qsub(lim_lo, c);
      return 0;
   endfunction

   function automatic rsp_type control_step(longint sp, longint fb);
      longint one, two, kt, e0, nt, a, b, p, i, s, d, c;
      rsp_type r;
      one = longint'(FX_ONE);
      two = longint'(FX_TWO);
      kt = qsqrt(qdiv(qabs(ki), qabs(kd != 0 ? kd : kp)));
      if (sp > longint'(SETPOINT_MAX)) sp = longint'(SETPOINT_MAX);
      else if (sp < longint'(SETPOINT_MIN)) sp = longint'(SETPOINT_MIN);
      e0 = qsub(sp, fb);
      nt = qmul(filt_n, period);
      d = qmul(qmul(kd, filt_n), qadd(qsub(e0, qadd(e_hist1, e_hist1)), e_hist2));
      case (method)
         METHOD_FWD: begin
            a = qsub(nt, one);
            b = qsub(nt, two);
            p = qmul(kp, qsub(qadd(e0, qmul(b, e_hist1)), qmul(a, e_hist2)));
            i = qmul(qmul(ki, period), qsub(e_hist1, qmul(a, e_hist2)));
            s = qmul(qmul(kt, period),
                     qsub(windup_err(c_hist1), qmul(a, windup_err(c_hist2))));
            c = qadd(qadd(qadd(p, i), s), d);
            c = qsub(qadd(c, qmul(a, c_hist2)), qmul(b, c_hist1));
         end
         METHOD_BWD: begin
            a = qadd(nt, one);
            b = qadd(nt, two);
            p = qmul(kp, qsub(qadd(qmul(a, e0), e_hist2), qmul(b, e_hist1)));
            i = qmul(qmul(ki, period), qadd(qmul(a, e0), e_hist1));
            s = qmul(qmul(kt, period),
                     qadd(qmul(a, windup_err(c_hist1)), windup_err(c_hist1)));
            c = qadd(qadd(qadd(p, i), s), d);
            c = qdiv(qsub(qadd(c, qmul(b, c_hist1)), c_hist2), a);
         end
         METHOD_TRAP: begin
            a = qdiv(qsub(nt, two), two);
            b = qdiv(qadd(nt, two), two);
            p = qmul(qsub(qadd(qmul(b, e0), qadd(e_hist1, e_hist1)),
                          qmul(a, e_hist2)), kp);
            i = qadd(qadd(qmul(b, e0), qmul(nt, e_hist1)), qmul(a, e_hist2));
            i = qdiv(qmul(qmul(i, ki), period), two);
            s = qadd(qadd(qmul(b, windup_err(c_hist1)), qmul(nt, windup_err(c_hist1))),
                     qmul(a, windup_err(c_hist2)));
            s = qdiv(qmul(qmul(s, kt), period), two);
            c = qdiv(qadd(qadd(qadd(p, i), s), d), b);
         end
         default: c = c_hist1;
      endcase
      c_hist2 = c_hist1;
      c_hist1 = c;
      e_hist2 = e_hist1;
      e_hist1 = e0;
      if (c > lim_hi) r.drive = 32'(lim_hi);
      else if (c < lim_lo) r.drive = 32'(lim_lo);
      else r.drive = 32'(c);
      r.error_now = 32'(e0);
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         kp = 65536;
         ki = 0;
         kd = 0;
         filt_n = 65536;
         period = 65536;
         method = METHOD_FWD;
         lim_lo = -64'sd2147483648;
         lim_hi = 64'sd2147483647;
         c_hist1 = 0;
         c_hist2 = 0;
         e_hist1 = 0;
         e_hist2 = 0;
         drive_q.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_PROP_GAIN:     kp = longint'($signed(csr_wdata));
               REG_INTEG_GAIN:    ki = longint'($signed(csr_wdata));
               REG_DERIV_GAIN:    kd = longint'($signed(csr_wdata));
               REG_FILTER_COEF:   filt_n = longint'({33'd0, csr_wdata[30:0]});
               REG_SAMPLE_PERIOD: period = longint'({33'd0, csr_wdata[30:0]});
               REG_METHOD_SEL:    method = csr_wdata[1:0];
               REG_OUT_MIN:       lim_lo = longint'($signed(csr_wdata));
               REG_OUT_MAX:       lim_hi = longint'($signed(csr_wdata));
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            drive_q.push_back(control_step(longint'(req_data.target),
                                           longint'(req_data.measured)));
         if (rsp_valid && !rsp_stall) begin
            if (drive_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected response drive=%h error_now=%h",
                           rsp_data.drive, rsp_data.error_now);
            end else begin
               exp_r = drive_q.pop_front();
               if (rsp_data.drive !== exp_r.drive ||
                   rsp_data.error_now !== exp_r.error_now) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch drive exp %h got %h, error_now exp %h got %h",
                              exp_r.drive, rsp_data.drive,
                              exp_r.error_now, rsp_data.error_now);
               end
            end
         end
      end
      pending <= drive_q.size();
   end

endmodule

`default_nettype wire

// ----- sim/pid_antiwindup_controller_test.sv -----
`default_nettype none

module pid_antiwindup_controller_test;
   import pidaw_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;
   int          fail_count;
   int          pending;
   int          idle_cycles;
   logic        quiet;
   logic signed [31:0] set_pt, feedback;

   pid_antiwindup_controller i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pid_antiwindup_controller_check i_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= !quiet && ($urandom_range(99) < 24);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("pid_antiwindup_controller_test: errors");
            $finish;
         end
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic load_regs(input logic [31:0] p, input logic [31:0] i,
                            input logic [31:0] d, input logic [31:0] n,
                            input logic [31:0] dt, input logic [31:0] m,
                            input logic [31:0] lo, input logic [31:0] hi);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      write_reg(REG_PROP_GAIN, p);
      write_reg(REG_INTEG_GAIN, i);
      write_reg(REG_DERIV_GAIN, d);
      write_reg(REG_FILTER_COEF, n);
      write_reg(REG_SAMPLE_PERIOD, dt);
      write_reg(REG_METHOD_SEL, m);
      write_reg(REG_OUT_MIN, lo);
      write_reg(REG_OUT_MAX, hi);
      csr_valid <= 1'b0;
   endtask

   task automatic send(input logic [31:0] tgt, input logic [31:0] fb);
      while (!quiet && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data.target <= tgt;
      req_data.measured <= fb;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_gain();
      case ($urandom_range(9))
         0: return $urandom();
         1: return 32'd0;
         default: return 32'($urandom_range(524288)) - 32'd262144;
      endcase
   endfunction

   task automatic random_phase(input int count);
      logic [31:0] lo, hi, step;
      lo = $urandom();
      hi = $urandom();
      if ($urandom_range(3) != 0) begin
         lo = -32'($urandom_range(32'h0100_0000));
         hi = 32'($urandom_range(32'h0100_0000));
      end
      load_regs(pick_gain(), pick_gain(), ($urandom_range(2) == 0) ? 32'd0 : pick_gain(),
                ($urandom_range(4) == 0) ? $urandom() : 32'($urandom_range(1 << 20)),
                ($urandom_range(4) == 0) ? $urandom() : 32'($urandom_range(1 << 16)),
                {30'($urandom_range(32'h3fff_ffff)), 2'($urandom_range(3))}, lo, hi);
      set_pt = 32'($urandom_range(32'h0040_0000)) - 32'h0020_0000;
      feedback = 0;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(99) < 15) begin
            send($urandom(), $urandom());
         end else begin
            if ($urandom_range(19) == 0)
               set_pt = 32'($urandom_range(32'h0040_0000)) - 32'h0020_0000;
            step = 32'($urandom_range(32'h0002_0000)) - 32'h0001_0000;
            feedback = feedback + (set_pt - feedback) / 8 + $signed(step);
            send(set_pt, feedback);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      quiet = 1'b0;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = REG_PROP_GAIN;
      csr_wdata = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(32'h7fff_ffff, 32'h8000_0000);
      send(32'h8000_0000, 32'h7fff_ffff);
      send(32'h0000_0000, 32'h0000_0000);
      send(32'hffff_ffff, 32'h0001_0000);
      load_regs(32'h0001_0000, 32'h0000_8000, 32'h0000_1999, 32'h000a_0000,
                32'h0000_028f, 32'(METHOD_FWD), 32'hff9c_0000, 32'h0064_0000);
      send(32'h0010_0000, 32'h0000_0000);
      send(32'h0010_0000, 32'h0008_0000);
      load_regs(32'h0002_0000, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000,
                32'h0000_4000, 32'(METHOD_BWD), 32'hfff0_0000, 32'h0010_0000);
      send(32'h7fff_ffff, 32'h0000_0000);
      send(32'h8000_0000, 32'h0000_0000);
      load_regs(32'h0000_0000, 32'h0003_0000, 32'h0000_0000, 32'h7fff_ffff,
                32'h0000_0000, 32'(METHOD_TRAP), 32'h0010_0000, 32'hfff0_0000);
      send(32'h0005_0000, 32'h0001_0000);
      send(32'h8000_0000, 32'h7fff_ffff);
      load_regs(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      send(32'h0001_0000, 32'h0002_0000);
      send(32'h7fff_ffff, 32'h8000_0000);
      load_regs(32'h8000_0000, 32'h0000_0000, 32'h7fff_ffff, 32'h0000_0000,
                32'h0001_0000, 32'(METHOD_FWD), 32'h8000_0000, 32'h7fff_ffff);
      send(32'h0001_0000, 32'h0000_0000);
      send(32'h8000_0000, 32'h7fff_ffff);

      for (int ph = 0; ph < 40; ph++) begin
         quiet = (ph == 7) || (ph == 8);
         random_phase(50);
      end
      quiet = 1'b0;
      req_valid <= 1'b0;
      @(posedge clock);

      while (pending != 0) @(posedge clock);
      repeat (500) @(posedge clock);
      if (fail_count == 0)
         $display("pid_antiwindup_controller_test: clean");
      else
         $display("pid_antiwindup_controller_test: errors");
      $finish;
   end

endmodule

`default_nettype wire
